// ----- rtl/trm_pkg.sv -----
// shared types, codes and constants of the tiny register machine execute unit
// used by trm_exec and tiny_register_machine_execute_unit; depends on nothing else
package trm_pkg;

   // default sizes of the register file
   localparam int DATA_WIDTH_DEF = 32;
   localparam int REG_COUNT_DEF  = 10;

   // fixed field and port widths
   localparam int PC_W         = 8;
   localparam int PROG_LEN_W   = 9;
   localparam int REQ_TDATA_W  = 96;
   localparam int RSP_TDATA_W  = 48;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [PROG_LEN_W-1:0] PROG_LEN_RESET = 9'd256;

   // register index taken from the word address
   localparam logic CSR_IDX_PROGRAM_LENGTH = 1'b0;

   // operand modes; every other code reads as a literal
   localparam logic [1:0] MODE_DIRECT   = 2'd0;
   localparam logic [1:0] MODE_INDIRECT = 2'd1;

   // special first-operand register numbers
   localparam logic [3:0] REG_PC     = 4'd10;
   localparam logic [3:0] REG_CURSOR = 4'd11;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_INC    = 4'd2,
      OP_DEC    = 4'd3,
      OP_INPUT  = 4'd4,
      OP_OUTPUT = 4'd5,
      OP_STORE  = 4'd6,
      OP_JMP    = 4'd7,
      OP_JPOS   = 4'd8,
      OP_JNEG   = 4'd9,
      OP_JZILCH = 4'd10,
      OP_CALL   = 4'd11,
      OP_RETURN = 4'd12
   } op_type;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_PC     = 3'd1,
      ERR_INPUT  = 3'd2,
      ERR_OPCODE = 3'd3,
      ERR_REG    = 3'd4
   } err_type;

   // where an operand lives once decoded
   typedef enum logic [1:0] {
      LOC_GEN,
      LOC_PC,
      LOC_CUR,
      LOC_LIT
   } loc_kind_type;

   // one instruction beat
   typedef struct packed {
      logic [3:0]  opcode;
      logic [1:0]  first_mode;
      logic [3:0]  first_reg;
      logic [1:0]  second_mode;
      logic [3:0]  second_reg;
      logic [31:0] literal_value;
      logic [7:0]  jump_target;
      logic [31:0] stream_value;
      logic        stream_valid;
   } req_type;

   // one result beat
   typedef struct packed {
      logic [PC_W-1:0] next_pc;
      logic [31:0]     out_value;
      logic            out_valid;
      logic            input_taken;
      err_type         error_code;
   } rsp_type;

   // general register writeback control
   typedef struct packed {
      logic       gen_we;
      logic [3:0] gen_idx;
   } wb_type;

endpackage

// ----- rtl/trm_exec.sv -----
// combinational execute stage: operand decode, error checks, alu, branch and state update
// depends on trm_pkg
module trm_exec #(
   parameter int DATA_WIDTH        = trm_pkg::DATA_WIDTH_DEF,
   parameter int GENERAL_REG_COUNT = trm_pkg::REG_COUNT_DEF
) (
   input  trm_pkg::req_type                 req,
   input  logic [DATA_WIDTH-1:0]            regs [GENERAL_REG_COUNT],
   input  logic [trm_pkg::PC_W-1:0]         pc,
   input  logic [31:0]                      cursor,
   input  logic [trm_pkg::PC_W-1:0]         ret_addr,
   input  logic [trm_pkg::PROG_LEN_W-1:0]   prog_len,
   output trm_pkg::rsp_type                 rsp,
   output trm_pkg::wb_type                  wb,
   output logic [DATA_WIDTH-1:0]            gen_wdata,
   output logic [trm_pkg::PC_W-1:0]         pc_next,
   output logic [31:0]                      cursor_next,
   output logic [trm_pkg::PC_W-1:0]         ret_next
);
   import trm_pkg::*;

   logic [DATA_WIDTH-1:0] lit_d;
   logic [DATA_WIDTH-1:0] sval_d;
   logic [DATA_WIDTH-1:0] pc_d;
   logic [DATA_WIDTH-1:0] cur_d;

   // operand views of the non-register sources, sign extended (pc zero extended) or cut
   assign lit_d  = DATA_WIDTH'(64'($signed(req.literal_value)));
   assign sval_d = DATA_WIDTH'(64'($signed(req.stream_value)));
   assign pc_d   = DATA_WIDTH'(pc);
   assign cur_d  = DATA_WIDTH'(64'($signed(cursor)));

   // general register read by number, zero for numbers past the file
   function automatic logic [DATA_WIDTH-1:0] gen_read(input logic [3:0] idx);
      logic [DATA_WIDTH-1:0] v;
      v = '0;
      for (int k = 0; k < GENERAL_REG_COUNT; k++) begin
         if (idx == 4'(k)) begin
            v = regs[k];
         end
      end
      return v;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] read_loc(input loc_kind_type kind,
                                                      input logic [3:0] idx);
      logic [DATA_WIDTH-1:0] v;
      unique case (kind)
         LOC_GEN: v = gen_read(idx);
         LOC_PC:  v = pc_d;
         LOC_CUR: v = cur_d;
         default: v = lit_d;
      endcase
      return v;
   endfunction

   always_comb begin
      op_type                op;
      loc_kind_type          fk, sk, dk;
      logic [3:0]            fi, si;
      logic                  f_bad, s_bad, uses_f, uses_s, writes, is_input, is_output;
      logic                  take_jump;
      logic [DATA_WIDTH-1:0] ptr, a, b, res;
      logic [PC_W-1:0]       pc_base;
      logic [31:0]           cur_wr;
      err_type               err;

      op        = op_type'(req.opcode);
      fk        = LOC_LIT;
      sk        = LOC_LIT;
      dk        = LOC_GEN;
      fi        = '0;
      si        = '0;
      f_bad     = 1'b0;
      s_bad     = 1'b0;
      ptr       = '0;
      res       = '0;
      writes    = 1'b0;
      is_input  = 1'b0;
      is_output = 1'b0;
      take_jump = 1'b0;
      ret_next  = ret_addr;

      // first operand: direct, indirect or literal
      if (req.first_mode == MODE_DIRECT || req.first_mode == MODE_INDIRECT) begin
         priority if (req.first_reg == REG_PC) begin
            dk = LOC_PC;
         end else if (req.first_reg == REG_CURSOR) begin
            dk = LOC_CUR;
         end else if ({1'b0, req.first_reg} < 5'(GENERAL_REG_COUNT)) begin
            dk = LOC_GEN;
         end else begin
            f_bad = 1'b1;
         end
         if (!f_bad) begin
            if (req.first_mode == MODE_DIRECT) begin
               fk = dk;
               fi = req.first_reg;
            end else begin
               ptr = read_loc(dk, req.first_reg);
               if (ptr >= DATA_WIDTH'(GENERAL_REG_COUNT)) begin
                  f_bad = 1'b1;
               end else begin
                  fk = LOC_GEN;
                  fi = ptr[3:0];
               end
            end
         end
      end

      // second operand: general registers only
      if (req.second_mode == MODE_DIRECT || req.second_mode == MODE_INDIRECT) begin
         if ({1'b0, req.second_reg} >= 5'(GENERAL_REG_COUNT)) begin
            s_bad = 1'b1;
         end else if (req.second_mode == MODE_DIRECT) begin
            sk = LOC_GEN;
            si = req.second_reg;
         end else begin
            ptr = gen_read(req.second_reg);
            if (ptr >= DATA_WIDTH'(GENERAL_REG_COUNT)) begin
               s_bad = 1'b1;
            end else begin
               sk = LOC_GEN;
               si = ptr[3:0];
            end
         end
      end

      uses_f = !(op == OP_JMP || op == OP_CALL || op == OP_RETURN);
      uses_s = (op == OP_ADD || op == OP_SUB || op == OP_STORE);

      // error checks in priority order
      priority if ({1'b0, pc} >= prog_len) begin
         err = ERR_PC;
      end else if (req.opcode > OP_RETURN) begin
         err = ERR_OPCODE;
      end else if (op == OP_INPUT && !req.stream_valid) begin
         err = ERR_INPUT;
      end else if ((uses_f && f_bad) || (uses_s && s_bad)) begin
         err = ERR_REG;
      end else begin
         err = ERR_NONE;
      end

      a = read_loc(fk, fi);
      b = read_loc(sk, si);

      // alu and branch decision
      unique case (op)
         OP_ADD:    begin res = a + b; writes = 1'b1; end
         OP_SUB:    begin res = a - b; writes = 1'b1; end
         OP_INC:    begin res = a + 1'b1; writes = 1'b1; end
         OP_DEC:    begin res = a - 1'b1; writes = 1'b1; end
         OP_INPUT:  begin res = sval_d; writes = 1'b1; is_input = 1'b1; end
         OP_OUTPUT: is_output = 1'b1;
         OP_STORE:  begin res = b; writes = 1'b1; end
         OP_JMP:    take_jump = 1'b1;
         OP_JPOS:   take_jump = (a != '0) && !a[DATA_WIDTH-1];
         OP_JNEG:   take_jump = a[DATA_WIDTH-1];
         OP_JZILCH: take_jump = (a == '0);
         OP_CALL: begin
            take_jump = 1'b1;
            ret_next  = pc + 1'b1;
         end
         OP_RETURN: ;
         default:   ;
      endcase

      // a write to pc restarts counting from the written value
      pc_base = (writes && fk == LOC_PC) ? res[PC_W-1:0] : pc;
      cur_wr  = (writes && fk == LOC_CUR) ? 32'(64'($signed(res))) : cursor;
      if (is_input) begin
         cur_wr = cur_wr + 1'b1;
      end

      priority if (op == OP_RETURN) begin
         pc_next = ret_addr;
      end else if (take_jump) begin
         pc_next = req.jump_target;
      end else begin
         pc_next = pc_base + 1'b1;
      end

      gen_wdata         = res;
      wb.gen_we         = writes && fk == LOC_GEN;
      wb.gen_idx        = fi;
      cursor_next       = cur_wr;
      rsp.next_pc       = pc_next;
      rsp.out_value     = is_output ? 32'(64'($signed(a))) : '0;
      rsp.out_valid     = is_output;
      rsp.input_taken   = is_input;
      rsp.error_code    = err;

      // an error leaves all state alone
      if (err != ERR_NONE) begin
         wb.gen_we       = 1'b0;
         pc_next         = pc;
         cursor_next     = cursor;
         ret_next        = ret_addr;
         rsp.next_pc     = pc;
         rsp.out_value   = '0;
         rsp.out_valid   = 1'b0;
         rsp.input_taken = 1'b0;
      end
   end

endmodule

// ----- rtl/tiny_register_machine_execute_unit.sv -----
// Executes one pre-decoded register machine instruction per accepted beat. A beat is
// captured in an input register, executed against the architectural state (general
// registers, pc, input cursor, return address) by a single combinational pass, and
// its result lands in an output register when the beat executes, which waits while the
// output register holds a result that has not been taken. One instruction completes
// per cycle while the result side is not stalled: the execute pass updates the state at
// the same edge that loads its result, so the next instruction always sees the finished
// state. A stalled result side holds at most one finished and one waiting instruction.
// program_length is written through the csr port at address 0; the user must write it
// only while the unit is idle, which the block itself does not enforce. It resets to 256.
// depends on trm_pkg and trm_exec
module tiny_register_machine_execute_unit #(
   parameter int DATA_WIDTH        = trm_pkg::DATA_WIDTH_DEF,
   parameter int GENERAL_REG_COUNT = trm_pkg::REG_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // instruction channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // opcode, first_mode, first_reg, second_mode, second_reg, literal_value,
   // jump_target, stream_value, stream_valid, zero fill
   input  logic [trm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // next_pc, out_value, out_valid, input_taken, error_code, zero fill
   output logic [trm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [trm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [trm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [trm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import trm_pkg::*;

   localparam int IDX_W = $clog2(GENERAL_REG_COUNT);

   req_type               item_ff, item_in;
   logic                  item_vld_ff, item_vld_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [DATA_WIDTH-1:0] regs_ff [GENERAL_REG_COUNT];
   logic [DATA_WIDTH-1:0] regs_in [GENERAL_REG_COUNT];
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [31:0]           cursor_ff, cursor_in;
   logic [PC_W-1:0]       ret_ff, ret_in;
   logic [PROG_LEN_W-1:0] prog_len_ff, prog_len_in;

   logic                  req_accept;
   logic                  advance;
   logic                  csr_write;
   rsp_type               exec_rsp;
   wb_type                exec_wb;
   logic [DATA_WIDTH-1:0] exec_wdata;
   logic [PC_W-1:0]       exec_pc;
   logic [31:0]           exec_cursor;
   logic [PC_W-1:0]       exec_ret;

   // handshake: the waiting beat executes when the result register is free or draining
   assign advance    = item_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !item_vld_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // unpack the instruction beat
   always_comb begin
      item_in = item_ff;
      if (req_accept) begin
         item_in.opcode        = req_tdata[3:0];
         item_in.first_mode    = req_tdata[5:4];
         item_in.first_reg     = req_tdata[9:6];
         item_in.second_mode   = req_tdata[11:10];
         item_in.second_reg    = req_tdata[15:12];
         item_in.literal_value = req_tdata[47:16];
         item_in.jump_target   = req_tdata[55:48];
         item_in.stream_value  = req_tdata[87:56];
         item_in.stream_valid  = req_tdata[88];
      end
   end

   always_comb begin
      priority if (req_accept) begin
         item_vld_in = 1'b1;
      end else if (advance) begin
         item_vld_in = 1'b0;
      end else begin
         item_vld_in = item_vld_ff;
      end
   end

   trm_exec #(
      .DATA_WIDTH        (DATA_WIDTH),
      .GENERAL_REG_COUNT (GENERAL_REG_COUNT)
   ) u_exec (
      .req         (item_ff),
      .regs        (regs_ff),
      .pc          (pc_ff),
      .cursor      (cursor_ff),
      .ret_addr    (ret_ff),
      .prog_len    (prog_len_ff),
      .rsp         (exec_rsp),
      .wb          (exec_wb),
      .gen_wdata   (exec_wdata),
      .pc_next     (exec_pc),
      .cursor_next (exec_cursor),
      .ret_next    (exec_ret)
   );

   // architectural state commits when an instruction executes
   always_comb begin
      regs_in   = regs_ff;
      pc_in     = pc_ff;
      cursor_in = cursor_ff;
      ret_in    = ret_ff;
      if (advance) begin
         pc_in     = exec_pc;
         cursor_in = exec_cursor;
         ret_in    = exec_ret;
         if (exec_wb.gen_we) begin
            regs_in[exec_wb.gen_idx[IDX_W-1:0]] = exec_wdata;
         end
      end
   end

   // result register
   always_comb begin
      rsp_in = advance ? exec_rsp : rsp_ff;
      priority if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   // configuration write and read back
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready  = 1'b1;
   assign prog_len_in = (csr_write && csr_paddr[2] == CSR_IDX_PROGRAM_LENGTH)
                        ? csr_pwdata[PROG_LEN_W-1:0] : prog_len_ff;
   assign csr_prdata  = (csr_paddr[2] == CSR_IDX_PROGRAM_LENGTH)
                        ? CSR_DATA_W'(prog_len_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         pc_ff       <= '0;
         cursor_ff   <= '0;
         ret_ff      <= '0;
         prog_len_ff <= PROG_LEN_RESET;
         for (int k = 0; k < GENERAL_REG_COUNT; k++) begin
            regs_ff[k] <= '0;
         end
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         pc_ff       <= pc_in;
         cursor_ff   <= cursor_in;
         ret_ff      <= ret_in;
         prog_len_ff <= prog_len_in;
         regs_ff     <= regs_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.error_code, rsp_ff.input_taken, rsp_ff.out_valid,
                        rsp_ff.out_value, rsp_ff.next_pc};

`ifndef SYNTHESIS
   // a failing instruction leaves pc, cursor and return address untouched
   assert property (@(posedge clock) disable iff (reset)
      (advance && exec_rsp.error_code != ERR_NONE) |=>
      (pc_ff == $past(pc_ff) && cursor_ff == $past(cursor_ff) && ret_ff == $past(ret_ff)))
      else $error("state changed on a failing instruction");

   // an error result carries no output word and consumes no input
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.error_code != ERR_NONE) |->
      (!rsp_ff.out_valid && !rsp_ff.input_taken))
      else $error("error result flags output or input");

   // a new result only follows an executed instruction
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(item_vld_ff))
      else $error("result appeared without an instruction");

   // the input side stalls only when both stages are full and the output is blocked
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (item_vld_ff && rsp_vld_ff && !rsp_tready))
      else $error("input stalled with room in the pipeline");
`endif

endmodule
